### rtl/core/command_line_tokenizer_defines.svh
// Assertion macros for the command line tokenizer.
// Both forms sample on the rising edge of i_clk and stay quiet while i_rst_n is low.
`ifndef COMMAND_LINE_TOKENIZER_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS

// Check the consequent in the same cycle as the antecedent.
`define CLT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("command_line_tokenizer: same-cycle check failed");

// Check the consequent in the cycle after the antecedent.
`define CLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("command_line_tokenizer: next-cycle check failed");

`else

`define CLT_ASSERT_SAME(label, ante, cons)
`define CLT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/core/clt_pkg.sv
`timescale 1ns / 1ps

package clt_pkg;

    localparam int CHAR_W = 8;
    localparam int POS_W  = 5;
    localparam int TOK_W  = 4;

    localparam logic [CHAR_W-1:0] CH_END = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SEP = 8'd32;
    localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;

    typedef enum logic {
        RD_IDLE,
        RD_ISSUE
    } t_rd_state;

endpackage

### rtl/core/command_line_tokenizer.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake          Payload
// input    in         i_valid / o_stall  i_rx_char
// output   out        o_valid / i_stall  o_line_byte, o_byte_position, o_token_total, o_last_byte
//
// One character is taken per cycle while a line is collected; a stored one writes the store once.
// A carriage return that closes a line with tokens stalls the input while the reader issues one
// line store read per cycle for each stored byte; each byte passes a registered read and an
// output register. A stall on the output holds the read pipeline and so lengthens the burst.
// Reset clears the position, token count and separator flag; the line store is not cleared.

`include "command_line_tokenizer_defines.svh"

module command_line_tokenizer
    import clt_pkg::*;
#(
    parameter int LINE_BYTES = 32,
    parameter int MAX_TOKENS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CHAR_W-1:0] i_rx_char,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CHAR_W-1:0] o_line_byte,
    output logic [POS_W-1:0]  o_byte_position,
    output logic [TOK_W-1:0]  o_token_total,
    output logic              o_last_byte
);

    localparam int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam logic [AW-1:0]    WP_FULL = AW'(LINE_BYTES - 1);
    localparam logic [TOK_W-1:0] TOK_MAX = TOK_W'(MAX_TOKENS);

    logic [AW-1:0]    r_wp, n_wp;
    logic [TOK_W-1:0] r_tok_cnt, n_tok_cnt;
    logic             r_after_sep, n_after_sep;

    logic              in_acc;
    logic              rd_busy;
    logic              start;
    logic              mem_we;
    logic [CHAR_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CHAR_W-1:0] mem_rdata;
    logic [TOK_W-1:0]  tok_first;

    assign o_stall = rd_busy;
    assign in_acc  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_tok_cnt   <= '0;
            r_after_sep <= 1'b0;
        end else begin
            r_wp        <= n_wp;
            r_tok_cnt   <= n_tok_cnt;
            r_after_sep <= n_after_sep;
        end
    end

    assign tok_first = (r_tok_cnt == '0) ? TOK_W'(1) : r_tok_cnt;

    always_comb begin
        n_wp        = r_wp;
        n_tok_cnt   = r_tok_cnt;
        n_after_sep = r_after_sep;
        mem_we      = 1'b0;
        mem_wdata   = i_rx_char;
        start       = 1'b0;
        if (in_acc) begin
            if (i_rx_char == CH_END) begin
                start       = (r_tok_cnt != '0);
                n_wp        = '0;
                n_tok_cnt   = '0;
                n_after_sep = 1'b0;
            end else if (r_wp != WP_FULL) begin
                if (i_rx_char != CH_SEP) begin
                    n_tok_cnt = tok_first;
                    if (r_after_sep) begin
                        if (tok_first < TOK_MAX) begin
                            n_tok_cnt = tok_first + TOK_W'(1);
                        end
                        n_after_sep = 1'b0;
                    end
                    mem_we = 1'b1;
                    n_wp   = r_wp + AW'(1);
                end else if (!r_after_sep) begin
                    // collapse a run of spaces into one separator
                    mem_we      = 1'b1;
                    mem_wdata   = CH_NUL;
                    n_wp        = r_wp + AW'(1);
                    n_after_sep = 1'b1;
                end
            end
        end
    end

    clt_line_mem #(
        .DEPTH (LINE_BYTES),
        .AW    (AW)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wp),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    clt_reader #(
        .AW (AW)
    ) u_reader (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_len           (r_wp),
        .i_tokens        (r_tok_cnt),
        .o_busy          (rd_busy),
        .o_re            (mem_re),
        .o_raddr         (mem_raddr),
        .i_rdata         (mem_rdata),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_line_byte     (o_line_byte),
        .o_byte_position (o_byte_position),
        .o_token_total   (o_token_total),
        .o_last_byte     (o_last_byte)
    );

    `CLT_ASSERT_SAME(a_tok_bound, 1'b1, r_tok_cnt <= TOK_MAX)
    `CLT_ASSERT_SAME(a_wp_bound, 1'b1, r_wp <= WP_FULL)
    `CLT_ASSERT_SAME(a_out_tok_nonzero, o_valid, o_token_total != '0)
    `CLT_ASSERT_NEXT(a_emit_stalls_input, start, o_stall && (r_wp == '0))

endmodule

### rtl/core/clt_line_mem.sv
`timescale 1ns / 1ps

module clt_line_mem
    import clt_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [CHAR_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [CHAR_W-1:0] o_rdata
);

    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data while the reader is stalled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/clt_reader.sv
`timescale 1ns / 1ps

module clt_reader
    import clt_pkg::*;
#(
    parameter int AW = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [AW-1:0]     i_len,
    input  logic [TOK_W-1:0]  i_tokens,
    output logic              o_busy,
    output logic              o_re,
    output logic [AW-1:0]     o_raddr,
    input  logic [CHAR_W-1:0] i_rdata,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CHAR_W-1:0] o_line_byte,
    output logic [POS_W-1:0]  o_byte_position,
    output logic [TOK_W-1:0]  o_token_total,
    output logic              o_last_byte
);

    t_rd_state r_state, n_state;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic [AW-1:0]    r_len, n_len;
    logic [TOK_W-1:0] r_tok, n_tok;

    logic             r_s1_vld;
    logic [AW-1:0]    r_s1_pos;
    logic [TOK_W-1:0] r_s1_tok;
    logic             r_s1_last;

    logic              r_out_vld;
    logic [CHAR_W-1:0] r_out_byte;
    logic [POS_W-1:0]  r_out_pos;
    logic [TOK_W-1:0]  r_out_tok;
    logic              r_out_last;

    logic adv2;
    logic adv1;
    logic issue;
    logic issue_last;

    assign adv2       = !r_out_vld || !i_stall;
    assign adv1       = !r_s1_vld || adv2;
    assign issue      = (r_state == RD_ISSUE) && adv1;
    assign issue_last = (r_ptr == (r_len - AW'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RD_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_len <= n_len;
        r_tok <= n_tok;
    end

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_len   = r_len;
        n_tok   = r_tok;
        unique case (r_state)
            RD_IDLE: begin
                if (i_start) begin
                    n_state = RD_ISSUE;
                    n_ptr   = '0;
                    n_len   = i_len;
                    n_tok   = i_tokens;
                end
            end
            RD_ISSUE: begin
                if (issue) begin
                    n_ptr = r_ptr + AW'(1);
                    if (issue_last) begin
                        n_state = RD_IDLE;
                    end
                end
            end
            default: n_state = RD_IDLE;
        endcase
    end

    // stage 1: memory read in flight, sideband follows the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv1) begin
            r_s1_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_pos  <= r_ptr;
            r_s1_tok  <= r_tok;
            r_s1_last <= issue_last;
        end
    end

    // stage 2: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv2) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && r_s1_vld) begin
            r_out_byte <= i_rdata;
            r_out_pos  <= POS_W'(r_s1_pos);
            r_out_tok  <= r_s1_tok;
            r_out_last <= r_s1_last;
        end
    end

    assign o_busy          = (r_state == RD_ISSUE);
    assign o_re            = issue;
    assign o_raddr         = r_ptr;
    assign o_valid         = r_out_vld;
    assign o_line_byte     = r_out_byte;
    assign o_byte_position = r_out_pos;
    assign o_token_total   = r_out_tok;
    assign o_last_byte     = r_out_last;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import clt_pkg::*;

    localparam int LINE_BYTES = 32;
    localparam int MAX_TOKENS = 8;

    typedef struct packed {
        logic [CHAR_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic [TOK_W-1:0]  tokens;
        logic              is_last;
    } t_line_item;

    class line_scoreboard;
        logic [CHAR_W-1:0] text_buf [LINE_BYTES];
        int                fill;
        int                words;
        bit                in_gap;
        t_line_item        expected_bytes [$];
        int                mismatches;
        int                checked;
        int                lines_out;

        function new();
            fill       = 0;
            words      = 0;
            in_gap     = 0;
            mismatches = 0;
            checked    = 0;
            lines_out  = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s", $realtime, what);
            end
        endfunction

        // Track the line being collected; on carriage return queue the whole line if it holds a token.
        function void take_char(logic [CHAR_W-1:0] c);
            if (c != CH_END) begin
                if (fill < LINE_BYTES - 1) begin
                    if (c != CH_SEP) begin
                        if (words == 0) words = 1;
                        if (in_gap) begin
                            if (words < MAX_TOKENS) words++;
                            in_gap = 0;
                        end
                        text_buf[fill] = c;
                        fill++;
                    end else if (!in_gap) begin
                        text_buf[fill] = CH_NUL;
                        fill++;
                        in_gap = 1;
                    end
                end
            end else begin
                if (words != 0) begin
                    for (int k = 0; k < fill; k++) begin
                        expected_bytes.push_back('{text_buf[k], POS_W'(k), TOK_W'(words),
                                                   (k + 1 == fill)});
                    end
                    lines_out++;
                end
                words  = 0;
                in_gap = 0;
                fill   = 0;
            end
        endfunction

        function void check_byte(t_line_item got);
            t_line_item want;
            checked++;
            if (expected_bytes.size() == 0) begin
                flag($sformatf("unexpected item: byte %h pos %0d tokens %0d last %b",
                               got.data, got.pos, got.tokens, got.is_last));
            end else begin
                want = expected_bytes.pop_front();
                if (got.data !== want.data || got.pos !== want.pos ||
                    got.tokens !== want.tokens || got.is_last !== want.is_last) begin
                    flag($sformatf({"mismatch: expected byte %h pos %0d tokens %0d last %b, ",
                                    "got byte %h pos %0d tokens %0d last %b"},
                                   want.data, want.pos, want.tokens, want.is_last,
                                   got.data, got.pos, got.tokens, got.is_last));
                end
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [CHAR_W-1:0] i_rx_char;
    logic              o_valid;
    logic              i_stall;
    logic [CHAR_W-1:0] o_line_byte;
    logic [POS_W-1:0]  o_byte_position;
    logic [TOK_W-1:0]  o_token_total;
    logic              o_last_byte;

    line_scoreboard sb = new();
    int             tx_gap_max  = 6;
    int             rx_stall_max = 6;
    int             chars_sent  = 0;

    command_line_tokenizer #(
        .LINE_BYTES(LINE_BYTES),
        .MAX_TOKENS(MAX_TOKENS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_char      (i_rx_char),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_line_byte    (o_line_byte),
        .o_byte_position(o_byte_position),
        .o_token_total  (o_token_total),
        .o_last_byte    (o_last_byte)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.take_char(i_rx_char);
            if (o_valid && !i_stall) begin
                sb.check_byte('{o_line_byte, o_byte_position, o_token_total, o_last_byte});
            end
        end
    end

    // Output side: hold off a random number of cycles before taking each item.
    initial begin
        int n;
        i_stall <= 1'b0;
        wait (i_rst_n);
        forever begin
            n = $urandom_range(0, rx_stall_max);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    function automatic logic [CHAR_W-1:0] text_char();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom_range(0, 255)); while (c == CH_END || c == CH_SEP);
        return c;
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] c);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_char <= c;
        do @(posedge i_clk); while (o_stall);
        chars_sent++;
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
        send_char(CH_END);
    endtask

    // Words of random text joined by runs of spaces, closed by a carriage return.
    task automatic send_words(input int n_words, input int min_len, input int max_len,
                              input bit lead);
        if (lead) repeat ($urandom_range(1, 3)) send_char(CH_SEP);
        for (int w = 0; w < n_words; w++) begin
            repeat ($urandom_range(min_len, max_len)) send_char(text_char());
            if (w < n_words - 1 || $urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) send_char(CH_SEP);
            end
        end
        send_char(CH_END);
    endtask

    // Drop valid and hold until every queued byte has come back.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int n_line;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_rx_char <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_line("a");
        send_line(" ab  c ");
        send_line("");
        send_line("  ");
        send_char(8'h00);
        send_char(8'hFF);
        send_char(CH_END);
        drain();

        n_line = 0;
        while (chars_sent < 100) begin
            tx_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 6;
            rx_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
            if (n_line == 0) begin
                send_words(1, 33, 40, 1'b0);
            end else if (n_line == 1) begin
                send_words($urandom_range(9, 12), 1, 2, 1'($urandom_range(0, 1)));
            end else begin
                case ($urandom_range(0, 9))
                    0: repeat ($urandom_range(1, 6)) send_char(CHAR_W'($urandom_range(0, 255)));
                    1: send_words($urandom_range(1, 3), 10, 16, 1'($urandom_range(0, 1)));
                    2: send_words($urandom_range(9, 14), 1, 3, 1'($urandom_range(0, 1)));
                    3: send_words(0, 1, 1, 1'b1);
                    default: send_words($urandom_range(1, 5), 1, 4, $urandom_range(0, 3) == 0);
                endcase
            end
            if ($urandom_range(0, 3) == 0) drain();
            n_line++;
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("testbench: %0d chars sent in %0d random lines, %0d lines emitted",
                 chars_sent, n_line, sb.lines_out);
        $display("testbench: %0d bytes checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("testbench: timeout");
        $display("testbench: done, errors");
        $finish;
    end

endmodule
